/* design/kpu_pkg.sv */
package kpu_pkg;

  // field widths of the item and result ports
  localparam int SIZE_W = 4;
  localparam int RANK_W = 29;
  localparam int ELEM_W = 4;

  // default largest set size
  localparam int MAX_N_DEF = 12;

  // factorial of 0..15, saturated at 2^29 (beyond any rank value)
  localparam int FACT_W = RANK_W + 1;
  localparam logic [FACT_W-1:0] FACT_SAT [16] = '{
    30'd1,         30'd1,         30'd2,         30'd6,
    30'd24,        30'd120,       30'd720,       30'd5040,
    30'd40320,     30'd362880,    30'd3628800,   30'd39916800,
    30'd479001600, 30'd536870912, 30'd536870912, 30'd536870912
  };

  // controller to datapath commands
  typedef struct packed {
    logic load;     // take a new item
    logic step_hi;  // upper two quotient bits
    logic step_lo;  // lower two quotient bits, pick and emit an element
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bad;   // item at the inputs gives an error result
    logic last;  // one element left in the list
  } stat_t;

endpackage

/* design/kpu_ctrl.sv */
module kpu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  kpu_pkg::stat_t stat_i,
  output kpu_pkg::cmd_t  cmd_o,
  output logic          busy_o
);
  import kpu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HI   = 3'b010,
    ST_LO   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          // an error result leaves straight from the load
          if (!stat_i.bad) begin
            state_d = ST_HI;
          end
        end
      end
      ST_HI: begin
        cmd_o.step_hi = 1'b1;
        state_d       = ST_LO;
      end
      ST_LO: begin
        cmd_o.step_lo = 1'b1;
        state_d       = stat_i.last ? ST_IDLE : ST_HI;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* design/kpu_dp.sv */
module kpu_dp #(
  parameter int MAX_N = kpu_pkg::MAX_N_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kpu_pkg::cmd_t               cmd_i,
  output kpu_pkg::stat_t              stat_o,
  input  logic [kpu_pkg::SIZE_W-1:0]  set_size_i,
  input  logic [kpu_pkg::RANK_W-1:0]  rank_i,
  output logic                        valid_o,
  output logic [kpu_pkg::ELEM_W-1:0]  element_o,
  output logic                        last_o,
  output logic                        bad_rank_o
);
  import kpu_pkg::*;

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int EW = $clog2(MAX_N + 1);
  localparam int MW = FACT_W + 4;
  localparam logic [5:0] MaxNV = 6'(MAX_N);

  logic [SIZE_W-1:0] m_q, m_d;
  logic [RANK_W-1:0] r_q, r_d;
  logic [1:0]        qh_q, qh_d;
  logic [EW-1:0]     avail_q [MAX_N];
  logic [EW-1:0]     avail_d [MAX_N];
  logic              valid_q, valid_d;
  logic [EW-1:0]     elem_q, elem_d;
  logic              last_q, last_d;
  logic              bad_q, bad_d;

  logic [FACT_W-1:0] fact;
  logic [MW-1:0]     base, b1, b2, b3, r_w, sub_v;
  logic [1:0]        qd;
  logic [SIZE_W-1:0] q_raw, q_c;
  logic [IW-1:0]     qi;

  // range check of the item at the inputs
  assign stat_o.bad  = (set_size_i == '0) || ({2'b00, set_size_i} > MaxNV) ||
                       (rank_i == '0) || ({1'b0, rank_i} > FACT_SAT[set_size_i]);
  assign stat_o.last = (m_q == SIZE_W'(1));

  // one radix-4 digit of rank / (m-1)!, upper pair then lower pair
  assign fact  = FACT_SAT[SIZE_W'(m_q - SIZE_W'(1))];
  assign base  = cmd_i.step_hi ? (MW'(fact) << 2) : MW'(fact);
  assign b1    = base;
  assign b2    = base << 1;
  assign b3    = b1 + b2;
  assign r_w   = MW'(r_q);

  always_comb begin
    priority if (r_w >= b3) begin
      qd = 2'd3; sub_v = b3;
    end else if (r_w >= b2) begin
      qd = 2'd2; sub_v = b2;
    end else if (r_w >= b1) begin
      qd = 2'd1; sub_v = b1;
    end else begin
      qd = 2'd0; sub_v = '0;
    end
  end

  // clamp the index into the remaining list
  assign q_raw = {qh_q, qd};
  assign q_c   = (q_raw >= m_q) ? SIZE_W'(m_q - SIZE_W'(1)) : q_raw;
  assign qi    = IW'(q_c);

  // next values
  always_comb begin
    m_d     = m_q;
    r_d     = r_q;
    qh_d    = qh_q;
    avail_d = avail_q;
    valid_d = 1'b0;
    elem_d  = elem_q;
    last_d  = last_q;
    bad_d   = bad_q;
    if (cmd_i.load) begin
      m_d = set_size_i;
      r_d = RANK_W'(rank_i - RANK_W'(1));
      for (int i = 0; i < MAX_N; i++) begin
        avail_d[i] = EW'(i + 1);
      end
      if (stat_o.bad) begin
        valid_d = 1'b1;
        elem_d  = '0;
        last_d  = 1'b1;
        bad_d   = 1'b1;
      end
    end else if (cmd_i.step_hi) begin
      qh_d = qd;
      r_d  = RANK_W'(r_w - sub_v);
    end else if (cmd_i.step_lo) begin
      r_d     = RANK_W'(r_w - sub_v);
      m_d     = SIZE_W'(m_q - SIZE_W'(1));
      valid_d = 1'b1;
      elem_d  = avail_q[qi];
      last_d  = stat_o.last;
      bad_d   = 1'b0;
      // close the gap left by the picked element
      for (int i = 0; i < MAX_N - 1; i++) begin
        if (IW'(i) >= qi) begin
          avail_d[i] = avail_q[i + 1];
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      m_q     <= '0;
    end else begin
      valid_q <= valid_d;
      m_q     <= m_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    qh_q    <= qh_d;
    avail_q <= avail_d;
    elem_q  <= elem_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

  assign valid_o    = valid_q;
  assign element_o  = ELEM_W'(elem_q);
  assign last_o     = last_q;
  assign bad_rank_o = bad_q;

  // an error result is always the only one
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && bad_q) |-> last_q)
    else $error("error result not flagged last");

  // a good element is never zero
  a_elem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !bad_q) |-> (elem_q != '0))
    else $error("zero element in a good result");

  // the list is used up exactly at the last good element
  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !bad_q) |-> (last_q == (m_q == '0)))
    else $error("last flag out of step with the list");

  // selecting an element needs a non-empty list
  a_step_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step_hi || cmd_i.step_lo) |-> (m_q != '0))
    else $error("step with an empty list");

endmodule

/* design/kth_permutation_unrank_unit.sv */
// the first element is strobed from the result register after the ST_HI and ST_LO steps that
// follow acceptance, each further one after another ST_HI, ST_LO pair; busy stays high
// through these steps and the next item is taken once the unit is back in idle; each element
// costs two radix-4 steps of the shared compare-subtract unit that divides the rank by (m-1)!
// an error item gives one result in the cycle after acceptance and the unit stays idle
// results are strobed for one cycle each; the receiver cannot stall
// rst_ni is asynchronous, active low, and returns the unit to idle with no result pending
module kth_permutation_unrank_unit #(
  parameter int MAX_N = kpu_pkg::MAX_N_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [kpu_pkg::SIZE_W-1:0]  set_size_i,
  input  logic [kpu_pkg::RANK_W-1:0]  rank_i,
  output logic                        valid_o,
  output logic [kpu_pkg::ELEM_W-1:0]  element_o,
  output logic                        last_o,
  output logic                        bad_rank_o
);
  import kpu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  kpu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // divider, element list and result registers
  kpu_dp #(
    .MAX_N(MAX_N)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .set_size_i(set_size_i),
    .rank_i    (rank_i),
    .valid_o   (valid_o),
    .element_o (element_o),
    .last_o    (last_o),
    .bad_rank_o(bad_rank_o)
  );

endmodule
